// ===== hw/rtl/prm_pkg.sv =====
// Package: shared types, constants and state codes of the packet rate meter.
`timescale 1ns / 1ps

package prm_pkg;

    // Configuration register map
    localparam int unsigned  CFG_ADDR_W    = 3;
    localparam logic         REG_WINDOW_MS = 1'b0;
    localparam logic [15:0]  WINDOW_MS_RST = 16'd1000;

    // Rate arithmetic: unsigned 16.16 quotient of a 32-bit byte sum
    localparam int unsigned  FRAC_BITS = 16;
    localparam int unsigned  QUO_W     = 32 + FRAC_BITS;
    localparam int unsigned  CNT_W     = $clog2(QUO_W);

    // Number of directions kept in the state memory
    localparam int unsigned  DIR_NUM   = 2;

    // Per-direction statistics entry held in memory
    typedef struct packed {
        logic [31:0] first_stamp;
        logic [31:0] window_start;
        logic [31:0] window_bytes;
        logic [31:0] packets_seen;
        logic [63:0] bytes_seen;
        logic [31:0] rate_value;
    } t_entry;

    localparam int unsigned  ENTRY_W = $bits(t_entry);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_WB
    } t_state;

endpackage

// ===== hw/rtl/prm_if.sv =====
// Interfaces: packet event channel and statistics result channel.
`timescale 1ns / 1ps

interface prm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] size;
    logic [31:0] now_ms;

    modport source (output valid, kind, size, now_ms, input ready);
    modport sink   (input valid, kind, size, now_ms, output ready);
endinterface

interface prm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packet_count;
    logic [63:0] byte_total;
    logic [31:0] rate;
    logic        rate_updated;
    logic [31:0] first_time;
    logic [31:0] last_time;

    modport source (output valid, packet_count, byte_total, rate, rate_updated,
                    first_time, last_time, input ready);
    modport sink   (input valid, packet_count, byte_total, rate, rate_updated,
                    first_time, last_time, output ready);
endinterface

// ===== hw/rtl/prm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/packet_traffic_rate_meter_top.sv =====
// Top level: windowed packet throughput meter for receive and send directions.
`timescale 1ns / 1ps

// One packet event is taken at a time. For an event that does not close
// its rate window, the direction's entry is read from the state memory in
// ST_IDLE, and in ST_READ it is updated, written back and loaded into the
// result register. An event that closes a window first runs through the
// bit-serial divider in ST_DIV, which forms bytes/ms in 16.16, and is then
// written back in ST_WB. The result register frees the input side: a new
// event is taken while the previous result is still waiting; the update
// stalls only if the result register is still full when the next one is
// ready. The window_ms register lies at byte address 0; a value of 0 acts
// as 1. The user must write it only while idle; it is not enforced.

module packet_traffic_rate_meter_top
    import prm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    prm_in_if.sink                i_in,
    prm_out_if.source             o_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);

    // Configuration
    logic [15:0] r_window_ms;
    logic        cfg_wr;

    // Sequencer and working registers
    t_state         r_state, n_state;
    logic           r_dir;
    logic [15:0]    r_size;
    logic [31:0]    r_now;
    t_entry         r_entry;
    logic           r_upd;
    logic [DIR_NUM-1:0] r_valid;

    // Divider
    logic [QUO_W-1:0] r_quo;
    logic [31:0]      r_rem;
    logic [31:0]      r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [32:0]      rem_sh;
    logic [32:0]      rem_sub;
    logic             quo_bit;
    logic [QUO_W-1:0] quo_next;
    logic [31:0]      quo_sat;

    // Memory port
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    t_entry             ram_wdata;

    // Update datapath
    t_entry      cur;
    t_entry      n_calc;
    logic        started;
    logic [31:0] elapsed;
    logic [32:0] wb_sum;
    logic [31:0] wb_sat;
    logic [15:0] win;
    logic        close;

    // Result register
    logic        r_out_valid;
    t_entry      r_out_entry;
    logic        r_out_upd;
    logic [31:0] r_out_now;
    logic        out_free;
    logic        out_load;
    t_entry      out_entry;
    logic        out_upd;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= WINDOW_MS_RST;
        end else if (cfg_wr && (i_paddr[CFG_ADDR_W-1] == REG_WINDOW_MS)) begin
            r_window_ms <= i_pwdata[15:0];
        end
    end

    assign o_prdata = (i_paddr[CFG_ADDR_W-1] == REG_WINDOW_MS) ? {16'b0, r_window_ms}
                                                                 : 32'b0;

    // ---------------------------------------------------------------
    // State memory, one entry per direction
    // ---------------------------------------------------------------
    prm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DIR_NUM)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dir),
        .i_wdata (ram_wdata),
        .i_raddr (i_in.kind),
        .o_rdata (ram_rdata)
    );

    // Mark an entry as started once written; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_dir] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Event update
    // ---------------------------------------------------------------
    always_comb begin
        started = r_valid[r_dir];
        cur     = started ? t_entry'(ram_rdata) : '0;
        elapsed = r_now - cur.window_start;
        wb_sum  = {1'b0, cur.window_bytes} + {17'b0, r_size};
        wb_sat  = wb_sum[32] ? 32'hFFFF_FFFF : wb_sum[31:0];
        win     = (r_window_ms == 16'd0) ? 16'd1 : r_window_ms;
        close   = started && (elapsed >= {16'b0, win});

        n_calc              = cur;
        n_calc.packets_seen = cur.packets_seen + 32'd1;
        n_calc.bytes_seen   = cur.bytes_seen + {48'b0, r_size};
        if (!started) begin
            n_calc.first_stamp  = r_now;
            n_calc.window_start = r_now;
        end else if (close) begin
            n_calc.window_start = r_now;
            n_calc.window_bytes = 32'b0;
        end else begin
            n_calc.window_bytes = wb_sat;
        end
    end

    // ---------------------------------------------------------------
    // Restoring divider step: one quotient bit per cycle
    // ---------------------------------------------------------------
    always_comb begin
        rem_sh   = {r_rem, r_quo[QUO_W-1]};
        rem_sub  = rem_sh - {1'b0, r_div};
        quo_bit  = (rem_sh >= {1'b0, r_div});
        quo_next = {r_quo[QUO_W-2:0], quo_bit};
        quo_sat  = (|quo_next[QUO_W-1:32]) ? 32'hFFFF_FFFF : quo_next[31:0];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        ram_wdata = r_entry;
        out_entry = r_entry;
        out_upd   = r_upd;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                ram_wdata = n_calc;
                out_entry = n_calc;
                out_upd   = 1'b0;
                if (close) begin
                    n_state = ST_DIV;
                end else if (out_free) begin
                    ram_we   = 1'b1;
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_WB;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    ram_we   = 1'b1;
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Capture the event, hold the new entry and run the divider
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dir  <= i_in.kind;
                r_size <= i_in.size;
                r_now  <= i_in.now_ms;
            end
            ST_READ: begin
                r_entry <= n_calc;
                r_upd   <= close;
                r_quo   <= {wb_sat, {FRAC_BITS{1'b0}}};
                r_rem   <= 32'b0;
                r_div   <= elapsed;
                r_cnt   <= '0;
            end
            ST_DIV: begin
                r_quo <= quo_next;
                r_rem <= quo_bit ? rem_sub[31:0] : rem_sh[31:0];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_entry.rate_value <= quo_sat;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_entry <= out_entry;
            r_out_upd   <= out_upd;
            r_out_now   <= r_now;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.packet_count = r_out_entry.packets_seen;
    assign o_out.byte_total   = r_out_entry.bytes_seen;
    assign o_out.rate         = r_out_entry.rate_value;
    assign o_out.rate_updated = r_out_upd;
    assign o_out.first_time   = r_out_entry.first_stamp;
    assign o_out.last_time    = r_out_now;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_READ))
        else $error("accepted event did not start a memory read");

    a_write_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (o_out.valid && r_valid[r_dir]))
        else $error("write-back without a result in the output register");

    a_div_closes_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_upd && r_div != 32'b0))
        else $error("divider running without a closed window");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> !out_load || !$past(out_load))
        else $error("result register overwritten while stalled");

endmodule

// ===== tb/tb_packet_traffic_rate_meter_top.sv =====
// Testbench: packet rate meter driven through its channels, checked against a local predictor.
`timescale 1ns / 1ps

module tb_packet_traffic_rate_meter_top;
    import prm_pkg::*;

    localparam int unsigned REG_SPARE      = 1;      // unmapped register index
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_AT        = 400;    // result count that starts the long hold
    localparam int          HOLD_LEN       = 300;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int          MAX_REPORT     = 20;
    localparam int          LONG_RUN       = 30;     // full packets inside one long window

    typedef struct packed {
        logic        kind;
        logic [15:0] size;
        logic [31:0] now_ms;
    } t_pkt;

    typedef struct packed {
        logic [31:0] packet_count;
        logic [63:0] byte_total;
        logic [31:0] rate;
        logic        rate_updated;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } t_stat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [CFG_ADDR_W-1:0] i_paddr;
    logic [31:0]           i_pwdata;
    logic [31:0]           o_prdata;
    logic                  o_pready;

    prm_in_if  in_if ();
    prm_out_if out_if ();

    packet_traffic_rate_meter_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state, one entry per direction
    logic [15:0] win_ms_cfg;
    logic        dir_open  [2];
    logic [31:0] dir_first [2];
    logic [31:0] dir_last  [2];
    logic [31:0] win_start [2];
    logic [31:0] win_sum   [2];
    logic [31:0] pkt_cnt   [2];
    logic [63:0] byte_cnt  [2];
    logic [31:0] dir_rate  [2];

    t_pkt  pkt_q [$];       // events waiting to be offered
    t_stat stat_q [$];      // expected statistics, oldest first
    logic [31:0] t_cur [2]; // timestamp cursor per direction for generated traffic

    int err_cnt = 0;

    // Apply one packet event to the predicted state and queue the expected statistics
    task automatic meter_event(input logic dir, input logic [15:0] nbytes,
                               input logic [31:0] stamp);
        logic [31:0]      elapsed;
        logic [31:0]      win;
        logic [32:0]      sum;
        logic [QUO_W-1:0] quo;
        t_stat            res;
        win = (win_ms_cfg == 16'd0) ? 32'd1 : {16'd0, win_ms_cfg};
        res.rate_updated = 1'b0;
        if (!dir_open[dir]) begin
            dir_open[dir]  = 1'b1;
            dir_first[dir] = stamp;
            win_start[dir] = stamp;
        end else begin
            elapsed = stamp - win_start[dir];
            sum = {1'b0, win_sum[dir]} + nbytes;
            win_sum[dir] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            // Close the window: bytes/ms in 16.16, saturate on overflow
            if (elapsed >= win) begin
                quo = {win_sum[dir], {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, elapsed};
                dir_rate[dir] = (quo[QUO_W-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
                win_start[dir] = stamp;
                win_sum[dir] = 32'd0;
                res.rate_updated = 1'b1;
            end
        end
        dir_last[dir] = stamp;
        byte_cnt[dir] = byte_cnt[dir] + nbytes;
        pkt_cnt[dir]  = pkt_cnt[dir] + 32'd1;
        res.packet_count = pkt_cnt[dir];
        res.byte_total   = byte_cnt[dir];
        res.rate         = dir_rate[dir];
        res.first_time   = dir_first[dir];
        res.last_time    = dir_last[dir];
        stat_q.push_back(res);
    endtask

    // Sender: bursts of random length with random gaps
    int   burst_left = 0;
    int   gap_left   = 0;
    t_pkt drv_pkt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                meter_event(in_if.kind, in_if.size, in_if.now_ms);
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pkt_q.size() > 0) begin
                    drv_pkt = pkt_q.pop_front();
                    in_if.valid  <= 1'b1;
                    in_if.kind   <= drv_pkt.kind;
                    in_if.size   <= drv_pkt.size;
                    in_if.now_ms <= drv_pkt.now_ms;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 9) < 2) begin
                        // long stretch with no idling
                        burst_left = $urandom_range(40, 120);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 6);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Compare one field and report a mismatch
    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORT)
                $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    // Receiver: stall pattern of its own plus one long hold-off
    int          results_seen = 0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic [31:0] mon_cycle    = 0;
    int          stall_mode   = 0;
    logic [31:0] stall_mask   = '1;
    t_stat       mon_exp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (stat_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORT)
                        $display("%0t: transaction expected none, actual count %0h",
                                 $time, out_if.packet_count);
                end else begin
                    mon_exp = stat_q.pop_front();
                    check_field("packet_count", mon_exp.packet_count, out_if.packet_count);
                    check_field("byte_total", mon_exp.byte_total, out_if.byte_total);
                    check_field("rate", mon_exp.rate, out_if.rate);
                    check_field("rate_updated", mon_exp.rate_updated, out_if.rate_updated);
                    check_field("first_time", mon_exp.first_time, out_if.first_time);
                    check_field("last_time", mon_exp.last_time, out_if.last_time);
                end
            end
            mon_cycle++;
            if (mon_cycle[5:0] == 6'd0) begin
                stall_mode = $urandom_range(0, 3);
                stall_mask = $urandom;
            end
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= 1'($urandom_range(0, 1));
                    2: out_if.ready <= stall_mask[mon_cycle[4:0]];
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("packet_traffic_rate_meter_top: mismatch");
                $finish;
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic cfg_write(input int unsigned idx, input logic [15:0] value);
        logic [31:0] word;
        word = {16'($urandom), value};
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= CFG_ADDR_W'(idx * 4);
        i_pwdata  <= word;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (idx == REG_WINDOW_MS)
            win_ms_cfg = word[15:0];
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic push_evt(input logic kind, input logic [15:0] size,
                            input logic [31:0] now_ms);
        t_pkt p;
        p.kind   = kind;
        p.size   = size;
        p.now_ms = now_ms;
        pkt_q.push_back(p);
    endtask

    // Hold until every queued event is accepted and every result has come
    task automatic wait_drained();
        while (pkt_q.size() != 0 || in_if.valid || stat_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Queue random traffic whose time steps straddle the current window length
    task automatic push_random(input int n);
        logic [31:0] win;
        logic [31:0] step;
        logic [15:0] size;
        logic        dir;
        int          r;
        win = (win_ms_cfg == 16'd0) ? 32'd1 : {16'd0, win_ms_cfg};
        // start some phases just below the tick wrap
        if ($urandom_range(0, 2) == 0) begin
            t_cur[0] = 32'hFFFF_FFFF - $urandom_range(0, 3 * win);
            t_cur[1] = 32'hFFFF_FFFF - $urandom_range(0, 3 * win);
        end
        for (int i = 0; i < n; i++) begin
            dir = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 4)
                step = $urandom;
            else if (r < 14)
                step = 32'd0;
            else if (r < 22)
                step = win - $urandom_range(0, 1);
            else
                step = $urandom_range(0, win / 3 + 1);
            t_cur[dir] = t_cur[dir] + step;
            r = $urandom_range(0, 99);
            if (r < 10)
                size = 16'd0;
            else if (r < 20)
                size = 16'hFFFF;
            else if (r < 40)
                size = 16'($urandom_range(0, 255));
            else
                size = 16'($urandom);
            push_evt(dir, size, t_cur[dir]);
        end
    endtask

    logic [31:0] sat_t;

    initial begin
        i_rst_n      = 1'b0;
        i_psel       = 1'b0;
        i_penable    = 1'b0;
        i_pwrite     = 1'b0;
        i_paddr      = '0;
        i_pwdata     = '0;
        in_if.valid  = 1'b0;
        in_if.kind   = 1'b0;
        in_if.size   = '0;
        in_if.now_ms = '0;
        out_if.ready = 1'b0;
        win_ms_cfg   = WINDOW_MS_RST;
        for (int d = 0; d < 2; d++) begin
            dir_open[d]  = 1'b0;
            dir_first[d] = '0;
            dir_last[d]  = '0;
            win_start[d] = '0;
            win_sum[d]   = '0;
            pkt_cnt[d]   = '0;
            byte_cnt[d]  = '0;
            dir_rate[d]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First events of both directions, window close, close across tick wrap
        push_evt(1'b0, 16'hFFFF, 32'd0);
        push_evt(1'b1, 16'd0, 32'hFFFF_FFF0);
        push_evt(1'b0, 16'd100, 32'd500);
        push_evt(1'b0, 16'hFFFF, 32'd1000);
        push_evt(1'b1, 16'd200, 32'h0000_03D8);
        push_evt(1'b0, 16'd1, 32'd1001);
        push_evt(1'b0, 16'd5, 32'd1999);
        push_evt(1'b0, 16'd0, 32'd2000);
        wait_drained();

        // Shortest window: rate saturates at the top of the range
        cfg_write(REG_WINDOW_MS, 16'd1);
        push_evt(1'b0, 16'hFFFF, 32'd3000);
        push_evt(1'b0, 16'hFFFF, 32'd3000);
        push_evt(1'b0, 16'hFFFF, 32'd3001);
        push_evt(1'b1, 16'd7, 32'h0000_03D9);
        wait_drained();

        // Zero window acts as one: never close on zero elapsed time
        cfg_write(REG_WINDOW_MS, 16'd0);
        push_evt(1'b1, 16'd9, 32'd500);
        push_evt(1'b1, 16'd3, 32'd500);
        push_evt(1'b1, 16'd4, 32'd501);
        wait_drained();

        // Write to an unmapped register must leave the window alone
        cfg_write(REG_SPARE, 16'd5);
        push_evt(1'b0, 16'd2, 32'd5000);
        push_evt(1'b0, 16'd3, 32'd5000);
        push_evt(1'b0, 16'd0, 32'd5001);
        wait_drained();

        // Random traffic under several window lengths
        t_cur[0] = 32'd5001;
        t_cur[1] = 32'd501;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cfg_write(REG_WINDOW_MS, 16'd1000);
                1: cfg_write(REG_WINDOW_MS, 16'd1);
                2: cfg_write(REG_WINDOW_MS, 16'hFFFF);
                3: cfg_write(REG_WINDOW_MS, 16'd0);
                4: cfg_write(REG_WINDOW_MS, 16'($urandom_range(2, 64)));
                default: cfg_write(REG_WINDOW_MS, 16'($urandom_range(1, 65535)));
            endcase
            push_random(300);
            wait_drained();
        end

        // Fill a long window, then close over the longest elapsed time
        cfg_write(REG_WINDOW_MS, 16'hFFFF);
        sat_t = t_cur[1] + 32'd1;
        push_evt(1'b1, 16'd0, sat_t);
        sat_t = sat_t + 32'd65535;
        push_evt(1'b1, 16'd0, sat_t);
        for (int i = 0; i < LONG_RUN; i++)
            push_evt(1'b1, 16'hFFFF, sat_t);
        push_evt(1'b1, 16'hFFFF, sat_t - 32'd1);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("packet_traffic_rate_meter_top: match");
        else
            $display("packet_traffic_rate_meter_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/prm_pkg.sv
hw/rtl/prm_if.sv
hw/rtl/prm_ram.sv
hw/rtl/packet_traffic_rate_meter_top.sv
tb/tb_packet_traffic_rate_meter_top.sv
